>>> rtl/tslr_pkg.sv
// ----------------------------------------------------------------------------
// tslr_pkg: shared types and constants of the two-step line rasterizer
// Holds the field width, the default coordinate width and the command
// word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package tslr_pkg;

  localparam int unsigned FIELD_W        = 6;
  localparam int unsigned COORD_BITS_DEF = 6;

  typedef enum logic [2:0] {
    DP_IDLE      = 3'd0,
    DP_LOAD      = 3'd1,
    DP_SETUP     = 3'd2,
    DP_EMIT_NEAR = 3'd3,
    DP_EMIT_FAR  = 3'd4,
    DP_STEP      = 3'd5
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       far_end;
    logic [1:0] sel;
    logic       upd_d;
    logic       last;
  } dp_cmd_t;

endpackage

>>> rtl/tslr_ctrl.sv
// ----------------------------------------------------------------------------
// tslr_ctrl: sequencer of the two-step line rasterizer
// Takes one line, runs setup, then issues one pixel command per free output
// slot: both endpoints, the paired steps from each end, then the extras.
// ----------------------------------------------------------------------------
module tslr_ctrl #(
  parameter int unsigned COORD_BITS = tslr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [COORD_BITS-1:0]   da_i,
  input  logic [COORD_BITS-3:0]   len_i,
  output tslr_pkg::dp_cmd_t       cmd_o
);
  import tslr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [COORD_BITS-1:0] cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;
  logic [COORD_BITS-1:0] step_idx;
  logic                  in_loop;
  logic [1:0]            phase;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign step_idx    = cnt_q - COORD_BITS'(2);
  assign in_loop     = step_idx[COORD_BITS-1:2] < len_i;
  assign phase       = step_idx[1:0];
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o        = '0;
    cmd_o.op     = DP_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.op = DP_SETUP;
        cnt_d    = '0;
        state_d  = ST_RUN;
      end
      ST_RUN: begin
        if (out_free) begin
          if (cnt_q == '0) begin
            cmd_o.op = DP_EMIT_NEAR;
          end else if (cnt_q == COORD_BITS'(1)) begin
            cmd_o.op = DP_EMIT_FAR;
          end else begin
            cmd_o.op = DP_STEP;
          end
          if (in_loop) begin
            cmd_o.far_end = phase[1];
            cmd_o.sel     = {1'b0, phase[0]};
            cmd_o.upd_d   = (phase == 2'd3);
          end else begin
            cmd_o.far_end = (phase == 2'd2);
            cmd_o.sel     = phase;
            cmd_o.upd_d   = 1'b0;
          end
          cmd_o.last  = (cnt_q == da_i);
          out_valid_d = 1'b1;
          cnt_d       = cnt_q + COORD_BITS'(1);
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> cnt_q <= da_i)
    else $error("pixel count ran past the line length");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && out_free && cmd_o.last) |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after the last beat");

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_SETUP)
    else $error("accepted line did not enter setup");

  a_rise_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RUN)
    else $error("output beat raised outside the run state");

endmodule

>>> rtl/tslr_dp.sv
// ----------------------------------------------------------------------------
// tslr_dp: datapath of the two-step line rasterizer
// Holds the endpoints, octant and decision variable, computes the step
// pattern and advances either end by one pixel per command.
// ----------------------------------------------------------------------------
module tslr_dp #(
  parameter int unsigned COORD_BITS = tslr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  tslr_pkg::dp_cmd_t              cmd_i,
  input  logic [tslr_pkg::FIELD_W-1:0]   start_x_i,
  input  logic [tslr_pkg::FIELD_W-1:0]   start_y_i,
  input  logic [tslr_pkg::FIELD_W-1:0]   end_x_i,
  input  logic [tslr_pkg::FIELD_W-1:0]   end_y_i,
  output logic [COORD_BITS-1:0]          da_o,
  output logic [COORD_BITS-3:0]          len_o,
  output logic [tslr_pkg::FIELD_W-1:0]   pixel_x_o,
  output logic [tslr_pkg::FIELD_W-1:0]   pixel_y_o,
  output logic                           last_pixel_o
);
  import tslr_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 4;

  logic [CB-1:0]        x0_q, y0_q, x1_q, y1_q;
  logic [CB-1:0]        a0_q, b0_q, a1_q, b1_q;
  logic [CB-1:0]        a0_d, b0_d, a1_d, b1_d;
  logic                 sa_neg_q, sb_neg_q, swap_q, steep_q;
  logic [CB-1:0]        da_q;
  logic [CB-3:0]        len_q;
  logic signed [DW-1:0] c_q, incr1_q, incr2_q, d_q, d_d;
  logic [CB-1:0]        px_q, py_q;
  logic                 last_q;

  // setup arithmetic
  logic                 sx_neg, sy_neg, swap_c, steep_c;
  logic [CB-1:0]        adx, ady, da_c, db_c, da_m1;
  logic signed [DW-1:0] da_w, db_w, c_c, incr1_c, incr2_c, d_c;

  assign sx_neg  = x1_q < x0_q;
  assign sy_neg  = y1_q < y0_q;
  assign adx     = sx_neg ? x0_q - x1_q : x1_q - x0_q;
  assign ady     = sy_neg ? y0_q - y1_q : y1_q - y0_q;
  assign swap_c  = !(adx > ady);
  assign da_c    = swap_c ? ady : adx;
  assign db_c    = swap_c ? adx : ady;
  assign da_m1   = da_c - CB'(1);
  assign da_w    = DW'(da_c);
  assign db_w    = DW'(db_c);
  assign steep_c = (db_w <<< 1) >= da_w;
  assign incr2_c = (db_w <<< 2) - (da_w <<< 1);
  assign c_c     = steep_c ? ((db_w - da_w) <<< 1) : (db_w <<< 1);
  assign incr1_c = c_c <<< 1;
  assign d_c     = steep_c ? incr1_c + da_w : incr1_c - da_w;

  // step pattern from the decision variable
  logic       d_neg, d_pos, d_ltc, d_gtc, use_incr1;
  logic [3:0] pat;

  assign d_neg = d_q[DW-1];
  assign d_pos = !d_q[DW-1] && (d_q != '0);
  assign d_ltc = d_q < c_q;
  assign d_gtc = d_q > c_q;

  always_comb begin
    if (steep_q) begin
      use_incr1 = d_pos;
      if (d_pos) begin
        pat = 4'b0111;
      end else if (d_ltc) begin
        pat = 4'b0010;
      end else begin
        pat = {1'b0, d_gtc, 2'b01};
      end
    end else begin
      use_incr1 = d_neg;
      if (d_neg) begin
        pat = 4'b0000;
      end else if (d_ltc) begin
        pat = 4'b0010;
      end else begin
        pat = 4'b0101;
      end
    end
  end

  // single pixel step on the selected end
  logic          far, diag, a_dec, b_dec;
  logic [CB-1:0] a_sel, b_sel, a_nx, b_nx, ox, oy;

  assign far   = cmd_i.far_end;
  assign diag  = pat[cmd_i.sel];
  assign a_sel = far ? a1_q : a0_q;
  assign b_sel = far ? b1_q : b0_q;
  assign a_dec = sa_neg_q ^ far;
  assign b_dec = sb_neg_q ^ far;
  assign a_nx  = a_dec ? a_sel - CB'(1) : a_sel + CB'(1);
  assign b_nx  = !diag ? b_sel : (b_dec ? b_sel - CB'(1) : b_sel + CB'(1));

  always_comb begin
    a0_d = a0_q;
    b0_d = b0_q;
    a1_d = a1_q;
    b1_d = b1_q;
    d_d  = d_q;
    ox   = a0_q;
    oy   = b0_q;
    unique case (cmd_i.op)
      DP_EMIT_NEAR: begin
        ox = swap_q ? b0_q : a0_q;
        oy = swap_q ? a0_q : b0_q;
      end
      DP_EMIT_FAR: begin
        ox = swap_q ? b1_q : a1_q;
        oy = swap_q ? a1_q : b1_q;
      end
      DP_STEP: begin
        ox = swap_q ? b_nx : a_nx;
        oy = swap_q ? a_nx : b_nx;
        if (far) begin
          a1_d = a_nx;
          b1_d = b_nx;
        end else begin
          a0_d = a_nx;
          b0_d = b_nx;
        end
        if (cmd_i.upd_d) begin
          d_d = use_incr1 ? d_q + incr1_q : d_q + incr2_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      x0_q <= start_x_i[CB-1:0];
      y0_q <= start_y_i[CB-1:0];
      x1_q <= end_x_i[CB-1:0];
      y1_q <= end_y_i[CB-1:0];
    end
    if (cmd_i.op == DP_SETUP) begin
      a0_q     <= swap_c ? y0_q : x0_q;
      b0_q     <= swap_c ? x0_q : y0_q;
      a1_q     <= swap_c ? y1_q : x1_q;
      b1_q     <= swap_c ? x1_q : y1_q;
      sa_neg_q <= swap_c ? sy_neg : sx_neg;
      sb_neg_q <= swap_c ? sx_neg : sy_neg;
      swap_q   <= swap_c;
      steep_q  <= steep_c;
      da_q     <= da_c;
      len_q    <= da_m1[CB-1:2];
      c_q      <= c_c;
      incr1_q  <= incr1_c;
      incr2_q  <= incr2_c;
      d_q      <= d_c;
    end else begin
      a0_q <= a0_d;
      b0_q <= b0_d;
      a1_q <= a1_d;
      b1_q <= b1_d;
      d_q  <= d_d;
    end
    if (cmd_i.op == DP_EMIT_NEAR || cmd_i.op == DP_EMIT_FAR || cmd_i.op == DP_STEP) begin
      px_q   <= ox;
      py_q   <= oy;
      last_q <= cmd_i.last;
    end
  end

  assign da_o         = da_q;
  assign len_o        = len_q;
  assign pixel_x_o    = FIELD_W'(px_q);
  assign pixel_y_o    = FIELD_W'(py_q);
  assign last_pixel_o = last_q;

endmodule

>>> rtl/two_step_line_raster.sv
// ----------------------------------------------------------------------------
// two_step_line_raster: two-step line rasterizer
// Turns a pair of endpoints into the pixels of the line between them.
// ----------------------------------------------------------------------------
// Input channel: one beat carries start_x/start_y/end_x/end_y; it is taken
// when in_valid_i is high and in_stall_o is low. Only the low COORD_BITS bits
// of each coordinate are used.
// Output channel: one beat per pixel on pixel_x_o/pixel_y_o; last_pixel_o
// marks the final beat of a line. A line gives major delta + 1 beats: both
// endpoints first, then pixels stepped from both ends toward the middle.
// Start: a taken beat is loaded, setup runs, then the first pixel is registered.
// Throughput: one pixel per cycle while out_stall_i is low; a line passes
// through load, then setup, then one pixel per step. The single stepping
// unit of the datapath sets this rate.
// A new line is taken once the last pixel of the previous one has entered
// the output register, while that beat may still wait on the receiver.
// Stall: out_stall_i holds the output beat and pauses stepping.
// Reset: asynchronous, drops any line in progress and any pending beat.
// ----------------------------------------------------------------------------
module two_step_line_raster #(
  parameter int unsigned COORD_BITS = tslr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tslr_pkg::FIELD_W-1:0] start_x_i,
  input  logic [tslr_pkg::FIELD_W-1:0] start_y_i,
  input  logic [tslr_pkg::FIELD_W-1:0] end_x_i,
  input  logic [tslr_pkg::FIELD_W-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tslr_pkg::FIELD_W-1:0] pixel_x_o,
  output logic [tslr_pkg::FIELD_W-1:0] pixel_y_o,
  output logic                         last_pixel_o
);
  import tslr_pkg::*;

  dp_cmd_t               cmd;
  logic [COORD_BITS-1:0] da;
  logic [COORD_BITS-3:0] len;

  tslr_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .da_i        (da),
    .len_i       (len),
    .cmd_o       (cmd)
  );

  tslr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .da_o         (da),
    .len_o        (len),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule
